FILE: hdl/ifsk_pkg.sv
package ifsk_pkg;

  localparam int WORD_IN_W  = 8;
  localparam int INTERVAL_W = 16;
  localparam int TOGGLE_W   = 8;
  localparam int EMIT_W     = 4;
  localparam int SEL_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [INTERVAL_W-1:0] IDLE_INTERVAL = 16'd100;
  localparam logic [EMIT_W-1:0]     ALL_EMITTERS  = 4'hF;
  localparam logic [EMIT_W-1:0]     ONE_EMITTER   = 4'h1;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARK_INTERVAL  = 3'd0,
    REG_MARK_TOGGLES   = 3'd1,
    REG_SPACE_INTERVAL = 3'd2,
    REG_SPACE_TOGGLES  = 3'd3,
    REG_OMNI_MODE      = 3'd4,
    REG_EMITTER_SELECT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] mark_interval;
    logic [TOGGLE_W-1:0]   mark_toggles;
    logic [INTERVAL_W-1:0] space_interval;
    logic [TOGGLE_W-1:0]   space_toggles;
  } timing_t;

  typedef struct packed {
    timing_t          timing;
    logic             omni_mode;
    logic [SEL_W-1:0] emitter_select;
  } cfg_t;

  typedef struct packed {
    logic [EMIT_W-1:0]     emitter_levels;
    logic [INTERVAL_W-1:0] timer_interval;
    logic                  done_res;
    logic                  busy_res;
  } res_t;

endpackage

FILE: hdl/ifsk_frame_build.sv
module ifsk_frame_build #(
  parameter int WORD_BITS = 8
) (
  input  logic [ifsk_pkg::WORD_IN_W-1:0] word_value,
  output logic [WORD_BITS+3:0]           frame_bits
);

  localparam int EXT_W = (WORD_BITS > ifsk_pkg::WORD_IN_W) ? WORD_BITS : ifsk_pkg::WORD_IN_W;
  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic [EXT_W-1:0]     word_ext;
  logic [WORD_BITS-1:0] w;
  logic [CNT_W-1:0]     spaces;
  logic [1:0]           chk;

  // missing high word bits read as zero (marks)
  assign word_ext = EXT_W'(word_value);
  assign w        = word_ext[WORD_BITS-1:0];

  always_comb begin
    spaces = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      spaces = spaces + CNT_W'(w[i]);
    end
  end

  assign chk = 2'd0 - spaces[1:0];

  always_comb begin
    frame_bits = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      frame_bits[2+k] = w[WORD_BITS-1-k];
    end
    // checksum goes out high bit first
    frame_bits[WORD_BITS+2] = chk[1];
    frame_bits[WORD_BITS+3] = chk[0];
  end

endmodule

FILE: hdl/ifsk_tx_engine.sv
module ifsk_tx_engine #(
  parameter int WORD_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          func,
  input  logic [ifsk_pkg::WORD_IN_W-1:0] word_value,
  input  ifsk_pkg::cfg_t                cfg,
  output ifsk_pkg::res_t                res
);

  localparam int FRAME_BITS = WORD_BITS + 4;
  localparam int POS_W      = $clog2(FRAME_BITS + 1);
  localparam int IDX_W      = $clog2(FRAME_BITS);
  localparam int TW         = ifsk_pkg::TOGGLE_W;

  logic [FRAME_BITS-1:0]           built;
  logic [FRAME_BITS-1:0]           frame_bits, frame_bits_next;
  logic [POS_W-1:0]                bit_position, bit_position_next;
  logic                            pulse_level, pulse_level_next;
  logic [TW-1:0]                   toggle_count, toggle_count_next;
  logic [TW-1:0]                   toggle_limit, toggle_limit_next;
  logic [ifsk_pkg::INTERVAL_W-1:0] current_interval, current_interval_next;
  logic [ifsk_pkg::EMIT_W-1:0]     emitter_state, emitter_state_next;
  logic                            sending, sending_next;
  logic                            finished, finished_next;
  ifsk_pkg::timing_t               lat, lat_next;

  logic [TW:0]                     cnt_inc;
  logic [ifsk_pkg::EMIT_W-1:0]     mask;
  logic                            space;

  ifsk_frame_build #(.WORD_BITS(WORD_BITS)) u_build (
    .word_value (word_value),
    .frame_bits (built)
  );

  assign cnt_inc = {1'b0, toggle_count} + (TW+1)'(1);
  assign mask    = cfg.omni_mode ? ifsk_pkg::ALL_EMITTERS
                                 : (ifsk_pkg::ONE_EMITTER << cfg.emitter_select);
  assign space   = frame_bits[bit_position[IDX_W-1:0]];

  always_comb begin
    frame_bits_next       = frame_bits;
    bit_position_next     = bit_position;
    pulse_level_next      = pulse_level;
    toggle_count_next     = toggle_count;
    toggle_limit_next     = toggle_limit;
    current_interval_next = current_interval;
    emitter_state_next    = emitter_state;
    sending_next          = sending;
    finished_next         = finished;
    lat_next              = lat;
    if (advance) begin
      if (func == ifsk_pkg::FUNC_START) begin
        // first frame bit is always a mark: load it right away
        frame_bits_next       = built;
        lat_next              = cfg.timing;
        finished_next         = 1'b0;
        pulse_level_next      = 1'b0;
        sending_next          = 1'b1;
        toggle_count_next     = '0;
        current_interval_next = cfg.timing.mark_interval;
        toggle_limit_next     = cfg.timing.mark_toggles;
        bit_position_next     = POS_W'(1);
      end else if (sending) begin
        if (!pulse_level) begin
          emitter_state_next = emitter_state | mask;
        end else begin
          emitter_state_next = emitter_state & ~mask;
        end
        pulse_level_next  = ~pulse_level;
        toggle_count_next = cnt_inc[TW-1:0];
        if (cnt_inc >= {1'b0, toggle_limit}) begin
          if (bit_position < POS_W'(FRAME_BITS)) begin
            toggle_count_next     = '0;
            current_interval_next = space ? lat.space_interval : lat.mark_interval;
            toggle_limit_next     = space ? lat.space_toggles : lat.mark_toggles;
            bit_position_next     = bit_position + POS_W'(1);
          end else begin
            emitter_state_next    = '0;
            finished_next         = 1'b1;
            current_interval_next = ifsk_pkg::IDLE_INTERVAL;
            sending_next          = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits       <= '0;
      bit_position     <= '0;
      pulse_level      <= 1'b0;
      toggle_count     <= '0;
      toggle_limit     <= '0;
      current_interval <= ifsk_pkg::IDLE_INTERVAL;
      emitter_state    <= '0;
      sending          <= 1'b0;
      finished         <= 1'b0;
      lat              <= '0;
    end else begin
      frame_bits       <= frame_bits_next;
      bit_position     <= bit_position_next;
      pulse_level      <= pulse_level_next;
      toggle_count     <= toggle_count_next;
      toggle_limit     <= toggle_limit_next;
      current_interval <= current_interval_next;
      emitter_state    <= emitter_state_next;
      sending          <= sending_next;
      finished         <= finished_next;
      lat              <= lat_next;
    end
  end

  // result word carries the state after this item
  always_ff @(posedge clk) begin
    if (advance) begin
      res.emitter_levels <= emitter_state_next;
      res.timer_interval <= current_interval_next;
      res.done_res       <= finished_next;
      res.busy_res       <= sending_next;
    end
  end

`ifndef SYNTH
  a_busy_done_excl: assert property (@(posedge clk) disable iff (rst)
    !(sending && finished))
    else $error("busy and done both set");

  a_idle_dark: assert property (@(posedge clk) disable iff (rst)
    !sending |-> (emitter_state == '0))
    else $error("emitter lit while idle");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    sending |-> (bit_position != '0) && (bit_position <= POS_W'(FRAME_BITS)))
    else $error("bit position out of frame");

  a_done_interval: assert property (@(posedge clk) disable iff (rst)
    $rose(finished) |-> (current_interval == ifsk_pkg::IDLE_INTERVAL))
    else $error("frame end without idle interval");
`endif

endmodule

FILE: hdl/ir_fsk_frame_transmitter_core.sv
// Path: an accepted input word goes through the input register, then the result register,
//   to its result word; the frame state updates in the same cycle as the result.
// Throughput: one word per cycle, start or tick, while the output does not stall, as the
//   next-state logic of the transmit engine is combinational; output stalls back up into the input register.
// Reset: synchronous, active high; clears the frame state, sets interval to 100,
//   and returns the configuration registers to their defaults (omni mode on).
module ir_fsk_frame_transmitter_core #(
  parameter int WORD_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] word_value
  input  logic                            s_axis_tuser,   // [0] func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] emitter_levels, [19:4] timer_interval, [20] done_res, [21] busy_res
  output logic [23:0]                     m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [ifsk_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ifsk_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                           in_valid;
  logic                           in_func;
  logic [ifsk_pkg::WORD_IN_W-1:0] in_word;
  logic                           out_valid;
  logic                           advance;
  ifsk_pkg::cfg_t                 cfg;
  ifsk_pkg::res_t                 res;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func <= s_axis_tuser;
      in_word <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{timing: '0, omni_mode: 1'b1, emitter_select: '0};
    end else if (cfg_we) begin
      unique case (ifsk_pkg::reg_idx_t'(cfg_addr))
        ifsk_pkg::REG_MARK_INTERVAL:  cfg.timing.mark_interval  <= cfg_data;
        ifsk_pkg::REG_MARK_TOGGLES:   cfg.timing.mark_toggles   <= cfg_data[7:0];
        ifsk_pkg::REG_SPACE_INTERVAL: cfg.timing.space_interval <= cfg_data;
        ifsk_pkg::REG_SPACE_TOGGLES:  cfg.timing.space_toggles  <= cfg_data[7:0];
        ifsk_pkg::REG_OMNI_MODE:      cfg.omni_mode             <= cfg_data[0];
        ifsk_pkg::REG_EMITTER_SELECT: cfg.emitter_select        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  ifsk_tx_engine #(.WORD_BITS(WORD_BITS)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .func       (in_func),
    .word_value (in_word),
    .cfg        (cfg),
    .res        (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, res.busy_res, res.done_res, res.timer_interval,
                          res.emitter_levels};

endmodule
